// ===== rtl/slr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the stereo linear resampler
// Sample and rate widths, register indexes, budgets and item structs.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int FRAC_W   = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = CFG_IDX_W'(1);

    localparam logic [RATE_W-1:0] INPUT_RATE_RST  = RATE_W'(0);
    localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = RATE_W'(48000);

    localparam int MAX_OUT_FRAMES_DEF = 1024;
    localparam int MAX_IN_FRAMES_DEF  = 4096;

    // per-item result budgets
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] INTERP_CAP = CNT_W'(25);
    localparam logic [CNT_W-1:0] RESULT_CAP = CNT_W'(50);

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       run_last;
        logic                       block_done;
    } t_out_item;

    // queue entry between front and back
    typedef struct packed {
        t_in_item item;
        logic     pass;
    } t_job;

endpackage

// ===== rtl/slr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_stream_if: valid/ready stream channel
// Carries one item per handshake; payload type set by the instantiator.
// ----------------------------------------------------------------------------
interface slr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/slr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_front: input acceptance, classification and job queue
// Marks each frame as pass-through or resample and queues it for the back end.
// ----------------------------------------------------------------------------
module slr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [slr_pkg::RATE_W-1:0] i_input_rate,
    input  logic [slr_pkg::RATE_W-1:0] i_output_rate,
    slr_stream_if.sink                 i_in,
    output logic                       o_job_valid,
    output slr_pkg::t_job              o_job,
    input  logic                       i_job_pop
);
    localparam int DEPTH = slr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slr_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;
    logic             pass;

    assign pass = (i_input_rate == i_output_rate) || (i_input_rate == '0)
                  || (i_output_rate == '0);

    assign i_in.ready  = (r_count != CNT_W'(DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_job_valid = (r_count != '0);
    assign pop         = i_job_pop && o_job_valid;
    assign o_job       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + PTR_W'(1));
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + PTR_W'(1));
        end
        if (push && !pop) begin
            n_count = CNT_W'(r_count + CNT_W'(1));
        end else if (pop && !push) begin
            n_count = CNT_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{item: i_in.payload, pass: pass};
        end
    end

endmodule

// ===== rtl/slr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_div: restoring divider, one quotient bit per cycle
// Pulses done with the last quotient bit; divisor must hold during the run.
// ----------------------------------------------------------------------------
module slr_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial  = {r_rem, r_quot[NUM_W-1]};
    assign ge     = (trial >= {1'b0, i_den});
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= CW'(r_cnt - CW'(1));
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift numerator bits out the top, quotient bits in the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], ge};
            r_rem  <= ge ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
        end
    end

endmodule

// ===== rtl/slr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_back: resampling sequencer
// Walks output positions for each queued resample frame, interpolates, repeats the
// tail at buffer end, forwards pass-through frames and drives the output register.
// ----------------------------------------------------------------------------
module slr_back #(
    parameter int MAX_OUT_FRAMES = slr_pkg::MAX_OUT_FRAMES_DEF,
    parameter int MAX_IN_FRAMES  = slr_pkg::MAX_IN_FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [slr_pkg::RATE_W-1:0] i_input_rate,
    input  logic [slr_pkg::RATE_W-1:0] i_output_rate,
    input  logic                       i_cfg_we,
    input  logic                       i_job_valid,
    input  slr_pkg::t_job              i_job,
    output logic                       o_job_pop,
    slr_stream_if.source               o_out
);
    localparam int SW    = slr_pkg::SAMPLE_W;
    localparam int RW    = slr_pkg::RATE_W;
    localparam int FRW   = slr_pkg::FRAC_W;
    localparam int CW    = slr_pkg::CNT_W;
    localparam int OW    = $clog2(MAX_OUT_FRAMES + 1);
    localparam int FW    = $clog2(MAX_IN_FRAMES + 1);
    localparam int PW    = OW + RW + FRW;
    localparam int IXW   = PW - FRW;
    localparam int TW    = ((OW + 1) > FW) ? (OW + 1 + RW) : (FW + RW);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_A    = 4'd1;
    localparam logic [3:0] ST_DIV_B    = 4'd2;
    localparam logic [3:0] ST_CHECK    = 4'd3;
    localparam logic [3:0] ST_INTERP   = 4'd4;
    localparam logic [3:0] ST_HOLD     = 4'd5;
    localparam logic [3:0] ST_TAIL_MUL = 4'd6;
    localparam logic [3:0] ST_TAIL     = 4'd7;
    localparam logic [3:0] ST_FINISH   = 4'd8;

    function automatic logic signed [SW-1:0] lerp(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b,
        input logic [FRW-1:0]       frac
    );
        logic signed [SW:0]         diff;
        logic signed [SW+FRW+1:0]   prod;
        diff = (SW+1)'(b) - (SW+1)'(a);
        prod = diff * $signed({1'b0, frac});
        // drop the fraction bits: floor toward minus infinity
        return a + $signed(prod[SW+FRW-1:FRW]);
    endfunction

    logic [3:0]            r_state, n_state;
    slr_pkg::t_job         r_job, n_job;
    logic signed [SW-1:0]  r_held_l, n_held_l;
    logic signed [SW-1:0]  r_held_r, n_held_r;
    logic [FW-1:0]         r_frames_seen, n_frames_seen;
    logic [OW-1:0]         r_outputs_made, n_outputs_made;
    logic [PW-1:0]         r_pos, n_pos;
    logic [RW-1:0]         r_rem, n_rem;
    logic [PW-1:0]         r_step_q, n_step_q;
    logic [RW-1:0]         r_step_r, n_step_r;
    logic                  r_dirty, n_dirty;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [OW+RW-1:0]      r_prod;
    logic [TW:0]           r_tail_a, n_tail_a;
    logic [TW-1:0]         r_tail_b, n_tail_b;
    logic                  r_pend_valid, n_pend_valid;
    logic signed [SW-1:0]  r_pend_l, n_pend_l;
    logic signed [SW-1:0]  r_pend_r, n_pend_r;
    logic                  r_out_valid, n_out_valid;
    slr_pkg::t_out_item    r_out, n_out;

    logic                  slot_free;
    logic                  om_full;
    logic [IXW-1:0]        idx;
    logic [IXW-1:0]        km1;
    logic [OW+RW-1:0]      pos_prod;
    logic [OW:0]           om_inc;
    logic [OW+RW:0]        tail_a0;
    logic [FW+RW-1:0]      tail_b0;
    logic [RW:0]           sum_r;
    logic                  carry;
    logic                  gen;
    logic signed [SW-1:0]  gen_l;
    logic signed [SW-1:0]  gen_r;
    logic                  div_start;
    logic [PW-1:0]         div_num;
    logic                  div_done;
    logic [PW-1:0]         div_quot;
    logic [RW-1:0]         div_rem;

    slr_div #(
        .NUM_W (PW),
        .DEN_W (RW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (i_output_rate),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign slot_free     = !r_out_valid || o_out.ready;
    assign om_full       = (r_outputs_made >= OW'(MAX_OUT_FRAMES));
    assign idx           = r_pos[PW-1:FRW];
    assign km1           = IXW'(r_frames_seen - FW'(1));
    assign pos_prod      = r_outputs_made * i_input_rate;
    assign om_inc        = {1'b0, r_outputs_made} + (OW+1)'(1);
    assign tail_a0       = om_inc * i_input_rate;
    assign tail_b0       = r_frames_seen * i_output_rate;
    assign sum_r         = {1'b0, r_rem} + {1'b0, r_step_r};
    assign carry         = (sum_r >= {1'b0, i_output_rate});
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state        = r_state;
        n_job          = r_job;
        n_held_l       = r_held_l;
        n_held_r       = r_held_r;
        n_frames_seen  = r_frames_seen;
        n_outputs_made = r_outputs_made;
        n_pos          = r_pos;
        n_rem          = r_rem;
        n_step_q       = r_step_q;
        n_step_r       = r_step_r;
        n_dirty        = r_dirty;
        n_cnt          = r_cnt;
        n_tail_a       = r_tail_a;
        n_tail_b       = r_tail_b;
        n_pend_valid   = r_pend_valid;
        n_pend_l       = r_pend_l;
        n_pend_r       = r_pend_r;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out          = r_out;
        o_job_pop      = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        gen            = 1'b0;
        gen_l          = r_held_l;
        gen_r          = r_held_r;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_cnt     = '0;
                    if (i_job.pass) begin
                        n_pend_valid = 1'b1;
                        n_pend_l     = i_job.item.left_in;
                        n_pend_r     = i_job.item.right_in;
                        n_state      = ST_FINISH;
                    end else if (r_dirty) begin
                        // rates changed: rebuild the position step first
                        div_start = 1'b1;
                        div_num   = PW'({i_input_rate, {FRW{1'b0}}});
                        n_state   = ST_DIV_A;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    n_step_q  = div_quot;
                    n_step_r  = div_rem;
                    div_start = 1'b1;
                    div_num   = {r_prod, {FRW{1'b0}}};
                    n_state   = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    n_pos   = div_quot;
                    n_rem   = div_rem;
                    n_dirty = 1'b0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_frames_seen < FW'(MAX_IN_FRAMES)) begin
                    n_state = (r_frames_seen != '0) ? ST_INTERP : ST_HOLD;
                end else begin
                    n_state = r_job.item.buffer_end ? ST_TAIL_MUL : ST_FINISH;
                end
            end
            ST_INTERP: begin
                if (slot_free) begin
                    if (om_full || (idx > km1)) begin
                        n_state = ST_HOLD;
                    end else begin
                        // positions behind the held frame are dropped
                        if ((idx == km1) && (r_cnt < slr_pkg::INTERP_CAP)) begin
                            gen   = 1'b1;
                            gen_l = lerp(r_held_l, r_job.item.left_in, r_pos[FRW-1:0]);
                            gen_r = lerp(r_held_r, r_job.item.right_in, r_pos[FRW-1:0]);
                        end
                        n_outputs_made = OW'(r_outputs_made + OW'(1));
                        n_rem = carry ? RW'(sum_r - {1'b0, i_output_rate}) : sum_r[RW-1:0];
                        n_pos = PW'(r_pos + r_step_q + PW'(carry));
                    end
                end
            end
            ST_HOLD: begin
                n_held_l      = r_job.item.left_in;
                n_held_r      = r_job.item.right_in;
                n_frames_seen = FW'(r_frames_seen + FW'(1));
                n_state       = r_job.item.buffer_end ? ST_TAIL_MUL : ST_FINISH;
            end
            ST_TAIL_MUL: begin
                // tail runs while (outputs_made + 1) * in <= frames_seen * out
                n_tail_a = (TW+1)'(tail_a0);
                n_tail_b = TW'(tail_b0);
                n_state  = ST_TAIL;
            end
            ST_TAIL: begin
                if (slot_free) begin
                    if (!om_full && (r_tail_a <= (TW+1)'(r_tail_b))) begin
                        gen            = (r_cnt < slr_pkg::RESULT_CAP);
                        n_outputs_made = OW'(r_outputs_made + OW'(1));
                        n_tail_a       = (TW+1)'(r_tail_a + (TW+1)'(i_input_rate));
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_pend_valid || slot_free) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out        = '{left_out: r_pend_l, right_out: r_pend_r,
                                         run_last: 1'b1,
                                         block_done: r_job.item.buffer_end};
                        n_pend_valid = 1'b0;
                    end
                    if (r_job.item.buffer_end) begin
                        n_held_l       = '0;
                        n_held_r       = '0;
                        n_frames_seen  = '0;
                        n_outputs_made = '0;
                        n_pos          = '0;
                        n_rem          = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new result releases the pending one, which is then not the last
        if (gen) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = '{left_out: r_pend_l, right_out: r_pend_r,
                                run_last: 1'b0, block_done: 1'b0};
            end
            n_pend_valid = 1'b1;
            n_pend_l     = gen_l;
            n_pend_r     = gen_r;
            n_cnt        = CW'(r_cnt + CW'(1));
        end

        if (i_cfg_we) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_held_l       <= '0;
            r_held_r       <= '0;
            r_frames_seen  <= '0;
            r_outputs_made <= '0;
            r_pos          <= '0;
            r_rem          <= '0;
            r_dirty        <= 1'b1;
            r_cnt          <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_held_l       <= n_held_l;
            r_held_r       <= n_held_r;
            r_frames_seen  <= n_frames_seen;
            r_outputs_made <= n_outputs_made;
            r_pos          <= n_pos;
            r_rem          <= n_rem;
            r_dirty        <= n_dirty;
            r_cnt          <= n_cnt;
            r_pend_valid   <= n_pend_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_step_q <= n_step_q;
        r_step_r <= n_step_r;
        r_prod   <= pos_prod;
        r_tail_a <= n_tail_a;
        r_tail_b <= n_tail_b;
        r_pend_l <= n_pend_l;
        r_pend_r <= n_pend_r;
        r_out    <= n_out;
    end

endmodule

// ===== rtl/stereo_linear_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler: linear-interpolation sample rate converter
// Converts buffers of stereo 16-bit frames from the input to the output rate.
// ----------------------------------------------------------------------------
// Frames enter on i_in and are queued two deep, so the source can run ahead
// while results drain on o_out. A pass-through frame (equal rates or a zero
// rate) is forwarded unchanged. A resampled frame visits a run of output
// positions (its results, dropped positions and one final check); the last
// frame of a buffer then repeats tail frames. After any rate write, the next
// resampled frame first runs two passes of the bit-serial divider to rebuild
// the position step. Output back-pressure stalls the sequencer.
// ----------------------------------------------------------------------------
module stereo_linear_resampler #(
    parameter int MAX_OUT_FRAMES = slr_pkg::MAX_OUT_FRAMES_DEF,
    parameter int MAX_IN_FRAMES  = slr_pkg::MAX_IN_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [slr_pkg::RATE_W-1:0]    i_cfg_data,
    slr_stream_if.sink                    i_in,
    slr_stream_if.source                  o_out
);
    logic [slr_pkg::RATE_W-1:0] r_input_rate;
    logic [slr_pkg::RATE_W-1:0] r_output_rate;
    logic                       job_valid;
    slr_pkg::t_job              job;
    logic                       job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rate  <= slr_pkg::INPUT_RATE_RST;
            r_output_rate <= slr_pkg::OUTPUT_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slr_pkg::CFG_INPUT_RATE:  r_input_rate  <= i_cfg_data;
                slr_pkg::CFG_OUTPUT_RATE: r_output_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    slr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_input_rate  (r_input_rate),
        .i_output_rate (r_output_rate),
        .i_in          (i_in),
        .o_job_valid   (job_valid),
        .o_job         (job),
        .i_job_pop     (job_pop)
    );

    slr_back #(
        .MAX_OUT_FRAMES (MAX_OUT_FRAMES),
        .MAX_IN_FRAMES  (MAX_IN_FRAMES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_input_rate  (r_input_rate),
        .i_output_rate (r_output_rate),
        .i_cfg_we      (i_cfg_we),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_pop     (job_pop),
        .o_out         (o_out)
    );

endmodule
